// ===== hdl/lrrd_pkg.sv =====
package lrrd_pkg;

    // field widths
    localparam int unsigned OP_W    = 2;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned STATE_W = 31;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned SIDE_W  = 16;
    localparam int unsigned MULT_W  = 15;
    localparam int unsigned PROD_W  = STATE_W + MULT_W;
    localparam int unsigned DIV_W   = VAL_W + 1;
    localparam int unsigned BIT_W   = 5;

    // generator constants
    localparam logic [STATE_W-1:0] LCG_M      = 31'h7FFF_FFFF;
    localparam logic [MULT_W-1:0]  LCG_A      = 15'd16807;
    localparam logic [STATE_W-1:0] SEED_RESET = 31'd1;

    // opcodes
    localparam logic [OP_W-1:0] OP_RAW   = 2'd0;
    localparam logic [OP_W-1:0] OP_RANGE = 2'd1;
    localparam logic [OP_W-1:0] OP_DICE  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;      // latch input beat
        logic mul;       // multiply state by a
        logic red;       // reduce product mod m into state
        logic div_init;  // start remainder of draw by divisor
        logic div_step;  // one restoring step
        logic acc;       // add one die to the sum
    } lrrd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            skip;      // result needs no draw
        logic            div_last;  // final remainder step
        logic            roll_last; // final die of the run
    } lrrd_stat_t;

endpackage

// ===== hdl/lrrd_datapath.sv =====
module lrrd_datapath #(
    parameter int MAX_ROLLS = 255
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [lrrd_pkg::OP_W-1:0]     opcode,
    input  logic signed [31:0]            range_low,
    input  logic signed [31:0]            range_high,
    input  logic [lrrd_pkg::CNT_W-1:0]    roll_count,
    input  logic [lrrd_pkg::SIDE_W-1:0]   side_count,
    input  logic                          cfg_write,
    input  logic [lrrd_pkg::STATE_W-1:0]  cfg_seed,
    input  lrrd_pkg::lrrd_cmd_t           cmd,
    output lrrd_pkg::lrrd_stat_t          stat,
    output logic [lrrd_pkg::VAL_W-1:0]    value
);

    logic [lrrd_pkg::STATE_W-1:0] state_reg, state_next;
    logic [lrrd_pkg::PROD_W-1:0]  prod_reg;
    logic [lrrd_pkg::OP_W-1:0]    op_reg;
    logic                         equal_reg;
    logic [lrrd_pkg::VAL_W-1:0]   base_reg;
    logic [lrrd_pkg::DIV_W-1:0]   div_reg, div_next;
    logic [lrrd_pkg::DIV_W-1:0]   rem_reg;
    logic [lrrd_pkg::STATE_W-1:0] dvd_reg;
    logic [lrrd_pkg::BIT_W-1:0]   bit_reg;
    logic [lrrd_pkg::CNT_W-1:0]   rolls_reg, rolls_next;
    logic [lrrd_pkg::VAL_W-1:0]   sum_reg;

    logic signed [32:0]           lo_ext, hi_ext, min_ext, max_ext;
    logic [lrrd_pkg::VAL_W-1:0]   fold;
    logic [lrrd_pkg::VAL_W-1:0]   fold_sub;
    logic [lrrd_pkg::DIV_W:0]     trial;
    logic [lrrd_pkg::DIV_W-1:0]   rem_next;

    // bounds ordering and divisor selection for a new beat
    always_comb
    begin
        lo_ext = 33'(range_low);
        hi_ext = 33'(range_high);
        if (lo_ext > hi_ext)
        begin
            min_ext = hi_ext;
            max_ext = lo_ext;
        end
        else
        begin
            min_ext = lo_ext;
            max_ext = hi_ext;
        end
        if (opcode == lrrd_pkg::OP_DICE)
            div_next = lrrd_pkg::DIV_W'(side_count);
        else
            div_next = lrrd_pkg::DIV_W'(max_ext - min_ext) + lrrd_pkg::DIV_W'(1);
        if (32'(roll_count) > MAX_ROLLS)
            rolls_next = lrrd_pkg::CNT_W'(MAX_ROLLS);
        else
            rolls_next = roll_count;
    end

    // fold product mod 2^31-1, zero maps to m
    always_comb
    begin
        fold = 32'(prod_reg[lrrd_pkg::PROD_W-1:lrrd_pkg::STATE_W])
             + 32'(prod_reg[lrrd_pkg::STATE_W-1:0]);
        if (fold >= 32'(lrrd_pkg::LCG_M))
            fold_sub = fold - 32'(lrrd_pkg::LCG_M);
        else
            fold_sub = fold;
        if (fold_sub == '0)
            state_next = lrrd_pkg::LCG_M;
        else
            state_next = fold_sub[lrrd_pkg::STATE_W-1:0];
    end

    // restoring remainder step
    always_comb
    begin
        trial = {rem_reg, dvd_reg[lrrd_pkg::STATE_W-1]};
        if (trial >= {1'b0, div_reg})
            rem_next = lrrd_pkg::DIV_W'(trial - {1'b0, div_reg});
        else
            rem_next = trial[lrrd_pkg::DIV_W-1:0];
    end

    // generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lrrd_pkg::SEED_RESET;
        else if (cfg_write)
            state_reg <= cfg_seed;
        else if (cmd.red)
            state_reg <= state_next;
    end

    // operand, product, divider and sum registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= opcode;
            equal_reg <= (range_low == range_high);
            base_reg  <= 32'(min_ext);
            div_reg   <= div_next;
            rolls_reg <= rolls_next;
            sum_reg   <= '0;
        end
        if (cmd.mul)
            prod_reg <= lrrd_pkg::PROD_W'(state_reg) * lrrd_pkg::PROD_W'(lrrd_pkg::LCG_A);
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            dvd_reg <= state_reg;
            bit_reg <= lrrd_pkg::BIT_W'(lrrd_pkg::STATE_W - 1);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[lrrd_pkg::STATE_W-2:0], 1'b0};
            bit_reg <= bit_reg - lrrd_pkg::BIT_W'(1);
        end
        if (cmd.acc)
        begin
            sum_reg   <= sum_reg + 32'(rem_reg) + 32'd1;
            rolls_reg <= rolls_reg - lrrd_pkg::CNT_W'(1);
        end
    end

    // status to the controller
    always_comb
    begin
        stat.op        = op_reg;
        stat.div_last  = (bit_reg == '0);
        stat.roll_last = (rolls_reg == lrrd_pkg::CNT_W'(1));
        case (op_reg)
            lrrd_pkg::OP_RAW:   stat.skip = 1'b0;
            lrrd_pkg::OP_RANGE: stat.skip = equal_reg;
            lrrd_pkg::OP_DICE:  stat.skip = (rolls_reg == '0) || (div_reg == '0);
            default:            stat.skip = 1'b1;
        endcase
    end

    // result per opcode
    always_comb
    begin
        case (op_reg)
            lrrd_pkg::OP_RAW:   value = 32'(state_reg);
            lrrd_pkg::OP_RANGE:
                if (equal_reg)
                    value = base_reg;
                else
                    value = rem_reg[lrrd_pkg::VAL_W-1:0] + base_reg;
            lrrd_pkg::OP_DICE:  value = sum_reg;
            default:            value = '0;
        endcase
    end

endmodule

// ===== hdl/lrrd_ctrl.sv =====
module lrrd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 out_free,
    output logic                 out_load,
    input  lrrd_pkg::lrrd_stat_t stat,
    output lrrd_pkg::lrrd_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_RED,
        S_DIVI,
        S_DIV,
        S_ACC,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_CHECK;
            S_CHECK:
                state_next = stat.skip ? S_DONE : S_MUL;
            S_MUL:
                state_next = S_RED;
            S_RED:
                state_next = (stat.op == lrrd_pkg::OP_RAW) ? S_DONE : S_DIVI;
            S_DIVI:
                state_next = S_DIV;
            S_DIV:
                if (stat.div_last)
                    state_next = (stat.op == lrrd_pkg::OP_DICE) ? S_ACC : S_DONE;
            S_ACC:
                state_next = stat.roll_last ? S_DONE : S_MUL;
            S_DONE:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // commands decoded from state
    always_comb
    begin
        in_ready     = (state_reg == S_IDLE);
        cmd.load     = (state_reg == S_IDLE) && in_valid;
        cmd.mul      = (state_reg == S_MUL);
        cmd.red      = (state_reg == S_RED);
        cmd.div_init = (state_reg == S_DIVI);
        cmd.div_step = (state_reg == S_DIV);
        cmd.acc      = (state_reg == S_ACC);
        out_load     = (state_reg == S_DONE) && out_free;
    end

endmodule

// ===== hdl/lehmer_random_range_dice.sv =====
// from input beat to result: a result that needs no draw skips the generator, and a dice
// sum draws once per roll (rolls capped at MAX_ROLLS)
// each draw is a multiply and a fold, and each remainder a 31-step restoring divider
// one item in flight: the next beat is taken the cycle after the result is loaded, and
// a finished result waits in the output register. reset sets the generator state to 1
// and empties the output register
module lehmer_random_range_dice #(
    parameter int MAX_ROLLS = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // range_low[31:0], range_high[63:32], roll_count[71:64], side_count[87:72]
    input  logic [87:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // value[31:0]
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    // seed_value[30:0]
    input  logic [30:0] cfg_data
);

    lrrd_pkg::lrrd_cmd_t  cmd;
    lrrd_pkg::lrrd_stat_t stat;
    logic [31:0]          value;
    logic                 out_free;
    logic                 out_load;
    logic                 out_valid_reg;
    logic [31:0]          out_data_reg;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    lrrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .out_load (out_load),
        .stat     (stat),
        .cmd      (cmd)
    );

    lrrd_datapath #(
        .MAX_ROLLS (MAX_ROLLS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .opcode     (s_tuser),
        .range_low  (s_tdata[31:0]),
        .range_high (s_tdata[63:32]),
        .roll_count (s_tdata[71:64]),
        .side_count (s_tdata[87:72]),
        .cfg_write  (cfg_valid),
        .cfg_seed   (cfg_data),
        .cmd        (cmd),
        .stat       (stat),
        .value      (value)
    );

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= value;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== bench/tb.sv =====
module tb;

    import lrrd_pkg::*;

    // generator constants for the Schrage step
    localparam longint MOD_M    = 2147483647;
    localparam longint MUL_A    = 16807;
    localparam longint SCHRAGE_Q = 127773;
    localparam longint SCHRAGE_R = 2836;

    localparam int          ROLL_CAP    = 255;
    localparam logic [31:0] INT_MIN     = 32'h8000_0000;
    localparam logic [31:0] INT_MAX     = 32'h7FFF_FFFF;
    localparam int          LONG_HOLD   = 400;
    localparam int          SETTLE      = 64;
    // slowest legal run stays well under this
    localparam int          CYCLE_LIMIT = 1_500_000;

    // phases after the directed part: fixed seeds first, then random ones
    localparam int N_PHASES = 7;
    localparam logic [30:0] PHASE_SEED [3] = '{31'd0, 31'h7FFF_FFFF, 31'd1};
    localparam int PHASE_ITEMS [N_PHASES] = '{30, 30, 100, 270, 270, 270, 270};
    localparam int PHASE_IDLE  [N_PHASES] = '{25, 10, 40, 0, 25, 15, 0};

    // one row of the directed table
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [7:0]  cnt;
        logic [15:0] sides;
        logic        known;
        logic [31:0] value;
    } dir_row_t;

    localparam int N_DIR = 22;
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        // first draw from the reset seed
        '{OP_RAW,   32'd0,   32'd0,   8'd0,   16'd0,      1'b1, 32'd16807},
        '{OP_RAW,   32'd0,   32'd0,   8'd0,   16'd0,      1'b0, 32'd0},
        // equal bounds give the bound back without a draw
        '{OP_RANGE, 32'd5,   32'd5,   8'd0,   16'd0,      1'b1, 32'd5},
        '{OP_RANGE, INT_MIN, INT_MIN, 8'd0,   16'd0,      1'b1, INT_MIN},
        '{OP_RANGE, INT_MAX, INT_MAX, 8'd0,   16'd0,      1'b1, INT_MAX},
        '{OP_RANGE, '1,      '1,      8'd0,   16'd0,      1'b1, '1},
        // full span, both orders
        '{OP_RANGE, INT_MIN, INT_MAX, 8'd0,   16'd0,      1'b0, 32'd0},
        '{OP_RANGE, INT_MAX, INT_MIN, 8'd0,   16'd0,      1'b0, 32'd0},
        // reversed and narrow spans
        '{OP_RANGE, 32'd10,  -32'sd10, 8'd0,  16'd0,      1'b0, 32'd0},
        '{OP_RANGE, 32'd0,   32'd1,   8'd0,   16'd0,      1'b0, 32'd0},
        '{OP_RANGE, INT_MAX - 32'd1, INT_MAX, 8'd0, 16'd0, 1'b0, 32'd0},
        // no dice
        '{OP_DICE,  32'd0,   32'd0,   8'd0,   16'd6,      1'b1, 32'd0},
        '{OP_DICE,  32'd0,   32'd0,   8'd3,   16'd0,      1'b1, 32'd0},
        '{OP_DICE,  32'd0,   32'd0,   8'd0,   16'd0,      1'b1, 32'd0},
        // one-sided dice always show one; then dice of more sides
        '{OP_DICE,  32'd0,   32'd0,   8'd1,   16'd1,      1'b1, 32'd1},
        '{OP_DICE,  32'd0,   32'd0,   8'd255, 16'd1,      1'b1, 32'd255},
        '{OP_DICE,  32'd0,   32'd0,   8'd2,   16'd6,      1'b0, 32'd0},
        '{OP_DICE,  32'd0,   32'd0,   8'd255, 16'hFFFF,   1'b0, 32'd0},
        '{OP_DICE,  32'd0,   32'd0,   8'd1,   16'hFFFF,   1'b0, 32'd0},
        // unused opcode gives zero whatever the data; then one more raw draw
        '{OP_NONE,  '1,      '1,      8'hFF,  16'hFFFF,   1'b1, 32'd0},
        '{OP_NONE,  32'd0,   32'd0,   8'd0,   16'd0,      1'b1, 32'd0},
        '{OP_RAW,   32'd0,   32'd0,   8'd0,   16'd0,      1'b0, 32'd0}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [30:0] cfg_data;

    logic [30:0] gen_state;
    logic [31:0] expected_values [$];
    int          errors;
    int          idle_pct;
    bit          long_hold;

    lehmer_random_range_dice #(
        .MAX_ROLLS (ROLL_CAP)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one step of the generator, Schrage form
    function automatic logic [30:0] step_generator();
        longint s;
        longint q_part;
        longint r_part;
        longint t;
        s = longint'(gen_state);
        q_part = s / SCHRAGE_Q;
        r_part = s % SCHRAGE_Q;
        t = MUL_A * r_part - SCHRAGE_R * q_part;
        if (t <= 0)
            t = t + MOD_M;
        gen_state = t[30:0];
        return gen_state;
    endfunction

    // value the block returns for one input beat
    function automatic logic [31:0] predict_value(input logic [1:0] op,
                                                  input logic [31:0] lo,
                                                  input logic [31:0] hi,
                                                  input logic [7:0] cnt,
                                                  input logic [15:0] sides);
        longint a;
        longint b;
        longint t;
        longint span;
        longint d;
        int     n;
        logic [31:0] sum;
        sum = '0;
        case (op)
            OP_RAW:
            begin
                sum = {1'b0, step_generator()};
            end
            OP_RANGE:
            begin
                a = $signed(lo);
                b = $signed(hi);
                if (a == b)
                    sum = lo;
                else
                begin
                    if (a > b)
                    begin
                        t = a;
                        a = b;
                        b = t;
                    end
                    span = b - a + 1;
                    d = longint'(step_generator()) % span;
                    t = d + a;
                    sum = t[31:0];
                end
            end
            OP_DICE:
            begin
                if (cnt != 0 && sides != 0)
                begin
                    n = (cnt > ROLL_CAP) ? ROLL_CAP : int'(cnt);
                    for (int i = 0; i < n; i++)
                        sum = sum + (step_generator() % sides) + 32'd1;
                end
            end
            default:
            begin
                sum = '0;
            end
        endcase
        return sum;
    endfunction

    // offer one beat, hold it until taken, then log what should come back
    task automatic offer_item(input logic [1:0] op, input logic [31:0] lo,
                              input logic [31:0] hi, input logic [7:0] cnt,
                              input logic [15:0] sides, input logic known,
                              input logic [31:0] fixed);
        logic [31:0] pred;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {sides, cnt, hi, lo};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = predict_value(op, lo, hi, cnt, sides);
        expected_values.push_back(known ? fixed : pred);
    endtask

    // random beat: mostly short dice runs, bounds pushed towards the edges
    task automatic offer_random();
        logic [1:0]  op;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [7:0]  cnt;
        logic [15:0] sides;
        int          pick;
        pick = $urandom_range(0, 99);
        op = (pick < 30) ? OP_RAW : (pick < 65) ? OP_RANGE : (pick < 95) ? OP_DICE : OP_NONE;
        lo = $urandom;
        hi = $urandom;
        if ($urandom_range(0, 63) == 0)
            cnt = 8'($urandom_range(0, 255));
        else
            cnt = 8'($urandom_range(0, 8));
        case ($urandom_range(0, 9))
            0:       sides = '0;
            1, 2:    sides = 16'($urandom);
            default: sides = 16'($urandom_range(1, 20));
        endcase
        case ($urandom_range(0, 9))
            0: hi = lo;
            1:
            begin
                lo = $urandom_range(0, 1) ? INT_MIN : INT_MAX;
                hi = lo ^ '1;
            end
            2: hi = lo + 32'($urandom_range(1, 1000));
            3: hi = lo - 32'($urandom_range(1, 1000));
            4: lo = $urandom_range(0, 1) ? INT_MIN : INT_MAX;
            default: ;
        endcase
        offer_item(op, lo, hi, cnt, sides, 1'b0, '0);
    endtask

    // random gap on the input side
    task automatic maybe_idle();
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17))
                @(posedge clk);
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_values.size() != 0)
            @(posedge clk);
    endtask

    // reload the seed while the block is idle
    task automatic load_seed(input logic [30:0] seed);
        cfg_valid <= 1'b1;
        cfg_data  <= seed;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        gen_state = seed;
    endtask

    // compare one result beat with the oldest expectation
    task automatic check_value(input logic [31:0] got);
        logic [31:0] want;
        if (expected_values.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result, expected none, got %h", $time, got);
        end
        else
        begin
            want = expected_values.pop_front();
            if (got !== want)
            begin
                errors++;
                $display("%0t: value mismatch, expected %h, got %h", $time, want, got);
            end
        end
    endtask

    // result side: random stalls plus one long hold-off on request
    initial
    begin : result_side
        int stall;
        stall = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_value(m_tdata);
            if (long_hold)
            begin
                long_hold = 1'b0;
                stall = LONG_HOLD;
            end
            else if (stall == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                stall = $urandom_range(1, 17);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // stimulus: directed table, then seeded phases of random beats
    initial
    begin : stimulus
        dir_row_t row;
        errors    = 0;
        idle_pct  = 20;
        long_hold = 1'b0;
        gen_state = SEED_RESET;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_RAW;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++)
        begin
            row = DIR_ROWS[i];
            offer_item(row.op, row.lo, row.hi, row.cnt, row.sides, row.known, row.value);
            maybe_idle();
        end
        drain();

        for (int p = 0; p < N_PHASES; p++)
        begin
            idle_pct = PHASE_IDLE[p];
            load_seed((p < 3) ? PHASE_SEED[p] : 31'($urandom));
            for (int i = 0; i < PHASE_ITEMS[p]; i++)
            begin
                // hold the result side off so the input backs up
                if (p == 4 && i == 40)
                    long_hold = 1'b1;
                offer_random();
                maybe_idle();
            end
            drain();
        end

        repeat (SETTLE)
            @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
